/* design/tcspq_pkg.sv */
// Shared types and codes for the three-class strict priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tcspq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int CLASS_W     = 2;
  localparam int S_USER_W    = 1 + CLASS_W;
  localparam int M_USER_W    = STATUS_W + CLASS_W + 1;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_DIRECTOR    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_COORDINATOR = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_EMPLOYEE    = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_CLASS = 3'd4;

  typedef struct packed {
    logic start;  // accept beat: decide, update pointers, access memory
    logic load;   // move finished result into the output register
  } tcspq_cmd_t;

endpackage

`default_nettype wire

/* design/three_class_strict_priority_queue.sv */
// Three-class strict priority queue (director > coordinator > employee).
// A request is taken, its result registered, then loaded into the output
// register; no new request is taken before that load, set by the registered read
// of the shared entry memory; a result may wait in the output register meanwhile.
// Reset (rst, synchronous): all queues empty, no result pending; entry memory
// is not cleared. Depends on tcspq_pkg, tcspq_ctrl, tcspq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module three_class_strict_priority_queue
  import tcspq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [DATA_W-1:0]   s_tdata,   // [31:0] payload
  input  wire  [S_USER_W-1:0] s_tuser,   // [0] req_type, [2:1] priority_class
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [DATA_W-1:0]   m_tdata,   // [31:0] out_payload
  output logic [M_USER_W-1:0] m_tuser    // [2:0] status, [4:3] out_class, [5] all_empty
);

  tcspq_cmd_t cmd;

  tcspq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tcspq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire

/* design/tcspq_ctrl.sv */
// Controller for the priority queue: request sequencing and output handshake.
// Depends on tcspq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcspq_ctrl
  import tcspq_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  wire        m_tready,
  output tcspq_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  always_comb begin
    s_tready  = (state == ST_IDLE);
    cmd.start = s_tvalid && s_tready;
    cmd.load  = (state == ST_EXEC) && (!out_valid || m_tready);
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.start) state_next = ST_EXEC;
      ST_EXEC: if (cmd.load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

  a_start_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_EXEC))
    else $error("start did not enter exec");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

  a_exec_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && out_valid && !m_tready) |=> (state == ST_EXEC))
    else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

/* design/tcspq_datapath.sv */
// Datapath for the priority queue: per-class pointers and counts, shared
// entry memory, result and output registers. Depends on tcspq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcspq_datapath
  import tcspq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  tcspq_cmd_t      cmd,
  input  wire  [DATA_W-1:0]     s_tdata,
  input  wire  [S_USER_W-1:0]   s_tuser,
  output logic [DATA_W-1:0]     m_tdata,
  output logic [M_USER_W-1:0]   m_tuser
);

  localparam int STORE_W = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D   = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_D);

  logic [STORE_W-1:0] mem [0:MEM_D-1];
  logic [STORE_W-1:0] rdata;

  logic [IDX_W-1:0] head [0:NUM_CLASSES-1];
  logic [IDX_W-1:0] tail [0:NUM_CLASSES-1];
  logic [CNT_W-1:0] count [0:NUM_CLASSES-1];
  logic [IDX_W-1:0] head_next [0:NUM_CLASSES-1];
  logic [IDX_W-1:0] tail_next [0:NUM_CLASSES-1];
  logic [CNT_W-1:0] count_next [0:NUM_CLASSES-1];

  logic               req;
  logic [CLASS_W-1:0] cls;
  logic [CNT_W-1:0]   sel_cnt;
  logic [IDX_W-1:0]   sel_tail;
  logic [CLASS_W-1:0] pick;
  logic [IDX_W-1:0]   pick_head;
  logic               found;
  logic               we;
  logic               re;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [STATUS_W-1:0] res_status_next;
  logic [CLASS_W-1:0]  res_class_next;

  logic [STATUS_W-1:0] res_status;
  logic [CLASS_W-1:0]  res_class;
  logic                res_all_empty;
  logic [STATUS_W-1:0] out_status;
  logic [CLASS_W-1:0]  out_class;
  logic                out_all_empty;
  logic [DATA_W-1:0]   out_payload;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    req       = s_tuser[0];
    cls       = s_tuser[2:1];
    sel_cnt   = '0;
    sel_tail  = '0;
    pick      = CLASS_DIRECTOR;
    pick_head = '0;
    found     = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls == CLASS_W'(c)) begin
        sel_cnt  = count[c];
        sel_tail = tail[c];
      end
    end
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (count[c] != '0) begin
        pick      = CLASS_W'(c);
        pick_head = head[c];
        found     = 1'b1;
      end
    end

    we = 1'b0;
    re = 1'b0;
    res_class_next = CLASS_DIRECTOR;
    if (req == REQ_ENQUEUE) begin
      if (cls == CLASS_UNKNOWN) begin
        res_status_next = ST_BAD_CLASS;
      end else if (sel_cnt == CNT_W'(QUEUE_DEPTH)) begin
        res_status_next = ST_FULL;
      end else begin
        res_status_next = ST_ENQUEUED;
        we = cmd.start;
      end
    end else if (found) begin
      res_status_next = ST_DEQUEUED;
      res_class_next  = pick;
      re = cmd.start;
    end else begin
      res_status_next = ST_EMPTY;
    end

    waddr = ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_tail);
    raddr = ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pick_head);

    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_next[c]  = head[c];
      tail_next[c]  = tail[c];
      count_next[c] = count[c];
      if (we && cls == CLASS_W'(c)) begin
        tail_next[c]  = next_slot(tail[c]);
        count_next[c] = count[c] + 1'b1;
      end
      if (re && pick == CLASS_W'(c)) begin
        head_next[c]  = next_slot(head[c]);
        count_next[c] = count[c] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= s_tdata[STORE_W-1:0];
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= head_next[c];
        tail[c]  <= tail_next[c];
        count[c] <= count_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_status    <= res_status_next;
      res_class     <= res_class_next;
      res_all_empty <= (count_next[0] == '0) && (count_next[1] == '0) &&
                       (count_next[2] == '0);
    end
    if (cmd.load) begin
      out_status    <= res_status;
      out_class     <= res_class;
      out_all_empty <= res_all_empty;
      out_payload   <= (res_status == ST_DEQUEUED) ? DATA_W'(rdata) : '0;
    end
  end

  assign m_tdata = out_payload;
  assign m_tuser = {out_all_empty, out_class, out_status};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count[0] <= CNT_W'(QUEUE_DEPTH)) && (count[1] <= CNT_W'(QUEUE_DEPTH)) &&
    (count[2] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire
